/* rtl/apq_pkg.sv */
package apq_pkg;

    // Queue geometry.
    localparam int QUEUE_DEPTH = 16;
    localparam int CW          = $clog2(QUEUE_DEPTH + 1);

    // Field widths.
    localparam int CODE_W   = 16;
    localparam int DEPT_W   = 3;
    localparam int ROLE_W   = 2;
    localparam int URG_W    = 4;
    localparam int PRI_W    = 8;
    localparam int WAIT_W   = 16;
    localparam int PERIOD_W = 8;
    localparam int WEIGHT_W = 4;
    localparam int STATUS_W = 3;
    localparam int CMD_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;

    localparam logic [PRI_W-1:0]  PRI_MAX  = '1;
    localparam logic [WAIT_W-1:0] WAIT_MAX = '1;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PRINT  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_AGE    = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_PRINTED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd5;
    localparam logic [STATUS_W-1:0] ST_AGED      = 3'd6;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ROLE_WEIGHT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEPT_WEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AGING_PERIOD = 2'd2;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [DEPT_W-1:0] dept;
        logic [ROLE_W-1:0] role;
        logic [URG_W-1:0]  urg;
        logic [PRI_W-1:0]  pri;
        logic [WAIT_W-1:0] waited;
    } job_t;

    typedef struct packed {
        logic valid;
        logic mark;
        job_t job;
    } slot_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_CLR,
        OP_WRITE,
        OP_MOVE,
        OP_POP
    } cell_op_t;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        cell_op_t        op;
        logic [CW-1:0]   tgt;
        job_t            x;
        logic            xmark;
    } cell_cmd_t;

endpackage

/* rtl/apq_cell.sv */
module apq_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [apq_pkg::CW-1:0] idx,
    input  apq_pkg::cell_cmd_t cmd,
    input  apq_pkg::slot_t     left_slot,
    input  logic               left_h,
    input  apq_pkg::slot_t     right_slot,
    input  logic               right_h,
    output apq_pkg::slot_t     slot,
    output logic               h
);

    apq_pkg::slot_t slot_reg;
    apq_pkg::slot_t slot_next;
    apq_pkg::slot_t x_slot;
    logic           is_tgt;
    logic           is_before;

    // A cell is "high" when it holds a job that the moving job must stay behind.
    assign h         = slot_reg.valid && (slot_reg.job.pri >= cmd.x.pri);
    assign is_tgt    = (idx == cmd.tgt);
    assign is_before = (idx < cmd.tgt);
    assign x_slot    = '{valid: 1'b1, mark: cmd.xmark, job: cmd.x};
    assign slot      = slot_reg;

    always_comb
    begin
        slot_next = slot_reg;
        case (cmd.op)
            apq_pkg::OP_CLR:
            begin
                slot_next.mark = 1'b0;
            end
            apq_pkg::OP_WRITE:
            begin
                if (is_tgt)
                begin
                    slot_next = x_slot;
                end
            end
            apq_pkg::OP_POP:
            begin
                slot_next = right_slot;
            end
            apq_pkg::OP_MOVE:
            begin
                if (is_before)
                begin
                    if (!left_h)
                    begin
                        slot_next = left_slot;
                    end
                    else if (!h)
                    begin
                        slot_next = x_slot;
                    end
                end
                else if (is_tgt)
                begin
                    if (right_h)
                    begin
                        slot_next = right_slot;
                    end
                    else if (left_h)
                    begin
                        slot_next = x_slot;
                    end
                    else
                    begin
                        slot_next = left_slot;
                    end
                end
                else
                begin
                    if (right_h)
                    begin
                        slot_next = right_slot;
                    end
                    else if (h)
                    begin
                        slot_next = x_slot;
                    end
                end
            end
            default:
            begin
                slot_next = slot_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
        end
        else
        begin
            slot_reg <= slot_next;
        end
    end

endmodule

/* rtl/apq_moddiv.sv */
module apq_moddiv (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [apq_pkg::WAIT_W-1:0]   dividend,
    input  logic [apq_pkg::PERIOD_W-1:0] divisor,
    output logic                         done,
    output logic [apq_pkg::PERIOD_W-1:0] rem
);

    localparam int CNT_W = $clog2(apq_pkg::WAIT_W);

    logic [apq_pkg::WAIT_W-1:0]   sh_reg;
    logic [apq_pkg::PERIOD_W-1:0] rem_reg;
    logic [apq_pkg::PERIOD_W-1:0] rem_step;
    logic [apq_pkg::PERIOD_W:0]   trial;
    logic [CNT_W-1:0]             cnt_reg;
    logic                         run_reg;
    logic                         done_reg;

    // One restoring step per cycle, most significant dividend bit first.
    assign trial = {rem_reg, sh_reg[apq_pkg::WAIT_W-1]};

    always_comb
    begin
        if (trial >= {1'b0, divisor})
        begin
            rem_step = apq_pkg::PERIOD_W'(trial - {1'b0, divisor});
        end
        else
        begin
            rem_step = trial[apq_pkg::PERIOD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (run_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(apq_pkg::WAIT_W - 1))
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sh_reg  <= dividend;
            rem_reg <= '0;
        end
        else if (run_reg)
        begin
            sh_reg  <= sh_reg << 1;
            rem_reg <= rem_step;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

/* rtl/aging_priority_queue.sv */
// Aging priority queue of print jobs. An item is taken when start is high
// and busy is low; busy then stays high until the item's single result has
// been shown. The result appears on the result ports for exactly one cycle,
// marked by done, and the receiver cannot hold it off, so it must sample it
// in that cycle. Every item first ages all queued jobs in queue order and
// then carries out its command (insert, print head, query by code, age only).
// The jobs sit in a chain of QUEUE_DEPTH cells, kept sorted by priority;
// every reposition, insert and pop is a single chain command in which the
// cells take a neighbor's job or the moving job. Each queued job passes a
// select state and an apply state, with a remainder division of the wait
// count by the aging period in between (skipped when the period is zero or
// the wait count is saturated); the aging pointer also steps over every
// already aged job in the select state. The command state then carries out
// the command, and a query goes on to search the jobs from the head, then
// gives its verdict. Configuration writes are always accepted and are
// meant to be made only while busy is low.
module aging_priority_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [apq_pkg::CMD_W-1:0]     command,
    input  logic [apq_pkg::DEPT_W-1:0]    department,
    input  logic [apq_pkg::ROLE_W-1:0]    role,
    input  logic [apq_pkg::URG_W-1:0]     urgency,
    input  logic [apq_pkg::CODE_W-1:0]    query_code,
    output logic                          done,
    output logic [apq_pkg::STATUS_W-1:0]  status,
    output logic [apq_pkg::CODE_W-1:0]    job_code,
    output logic [apq_pkg::DEPT_W-1:0]    job_department,
    output logic [apq_pkg::ROLE_W-1:0]    job_role,
    output logic [apq_pkg::URG_W-1:0]     job_urgency,
    output logic [apq_pkg::PRI_W-1:0]     job_priority,
    output logic [apq_pkg::WAIT_W-1:0]    job_wait,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [apq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [apq_pkg::CFG_DAT_W-1:0] cfg_data
);

    localparam int N  = apq_pkg::QUEUE_DEPTH;
    localparam int CW = apq_pkg::CW;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SEL   = 6'b000010,
        S_DIV   = 6'b000100,
        S_APPLY = 6'b001000,
        S_CMD   = 6'b010000,
        S_SCAN  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Configuration registers.
    logic [apq_pkg::WEIGHT_W-1:0] role_weight_reg;
    logic [apq_pkg::WEIGHT_W-1:0] dept_weight_reg;
    logic [apq_pkg::PERIOD_W-1:0] aging_period_reg;

    // Item held while it is worked on.
    logic [apq_pkg::CMD_W-1:0]  cmd_reg;
    logic [apq_pkg::DEPT_W-1:0] dept_reg;
    logic [apq_pkg::ROLE_W-1:0] role_reg;
    logic [apq_pkg::URG_W-1:0]  urg_reg;
    logic [apq_pkg::CODE_W-1:0] qcode_reg;

    // Queue control.
    logic [CW-1:0]              count_reg;
    logic [CW-1:0]              count_next;
    logic [CW-1:0]              n_reg;
    logic [CW-1:0]              n_next;
    logic [CW-1:0]              ptr_reg;
    logic [CW-1:0]              ptr_next;
    logic [CW-1:0]              aged_reg;
    logic [CW-1:0]              aged_next;
    logic [apq_pkg::CODE_W-1:0] next_code_reg;
    logic [apq_pkg::CODE_W-1:0] next_code_next;

    // Job under aging.
    apq_pkg::job_t job_reg;
    apq_pkg::job_t job_next;
    logic          raise_reg;
    logic          raise_next;
    apq_pkg::job_t aged_job;
    apq_pkg::job_t new_job;
    logic [apq_pkg::PRI_W:0] pri_sum;

    // Result registers.
    logic                         done_reg;
    logic                         done_next;
    logic [apq_pkg::STATUS_W-1:0] status_reg;
    logic [apq_pkg::STATUS_W-1:0] status_next;
    apq_pkg::job_t                out_reg;
    apq_pkg::job_t                out_next;

    // Cell chain.
    apq_pkg::cell_cmd_t cell_cmd;
    apq_pkg::slot_t     slots [N];
    logic               hs    [N];
    apq_pkg::slot_t     sel_slot;
    logic               back_flag;

    // Remainder unit.
    logic                         div_start;
    logic                         div_done;
    logic [apq_pkg::PERIOD_W-1:0] div_rem;

    logic accept;

    assign accept    = start && (state_reg == S_IDLE);
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    // The cells, each talking only to its neighbors.
    for (genvar k = 0; k < N; k++)
    begin : g_cell
        apq_pkg::slot_t l_slot;
        apq_pkg::slot_t r_slot;
        logic           l_h;
        logic           r_h;

        if (k == 0)
        begin : g_first
            assign l_slot = '0;
            assign l_h    = 1'b1;
        end
        else
        begin : g_mid_l
            assign l_slot = slots[k-1];
            assign l_h    = hs[k-1];
        end

        if (k == N - 1)
        begin : g_last
            assign r_slot = '0;
            assign r_h    = 1'b0;
        end
        else
        begin : g_mid_r
            assign r_slot = slots[k+1];
            assign r_h    = hs[k+1];
        end

        apq_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .idx        (CW'(k)),
            .cmd        (cell_cmd),
            .left_slot  (l_slot),
            .left_h     (l_h),
            .right_slot (r_slot),
            .right_h    (r_h),
            .slot       (slots[k]),
            .h          (hs[k])
        );
    end

    // The division starts in the select cycle, so it takes the freshly
    // incremented wait count before it reaches job_reg.
    apq_moddiv u_moddiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (job_next.waited),
        .divisor  (aging_period_reg),
        .done     (div_done),
        .rem      (div_rem)
    );

    // The cell under the pointer, and whether the cell after it stays ahead
    // of a moving job (a saturated job then moves toward the tail).
    always_comb
    begin
        sel_slot  = '0;
        back_flag = 1'b0;
        for (int k = 0; k < N; k++)
        begin
            if (CW'(k) == ptr_reg)
            begin
                sel_slot = sel_slot | slots[k];
            end
            if (CW'(k) == ptr_reg + 1'b1)
            begin
                back_flag = back_flag | hs[k];
            end
        end
    end

    // The aged job, with its priority raised by one when due.
    always_comb
    begin
        aged_job = job_reg;
        if (raise_reg && (job_reg.pri != apq_pkg::PRI_MAX))
        begin
            aged_job.pri = job_reg.pri + 1'b1;
        end
    end

    // Priority of a new job.
    assign pri_sum = (apq_pkg::PRI_W+1)'(role_reg) * (apq_pkg::PRI_W+1)'(role_weight_reg)
                   + (apq_pkg::PRI_W+1)'(dept_reg) * (apq_pkg::PRI_W+1)'(dept_weight_reg)
                   + (apq_pkg::PRI_W+1)'(urg_reg);

    always_comb
    begin
        new_job.code   = next_code_reg;
        new_job.dept   = dept_reg;
        new_job.role   = role_reg;
        new_job.urg    = urg_reg;
        new_job.pri    = pri_sum[apq_pkg::PRI_W] ? apq_pkg::PRI_MAX
                                                 : pri_sum[apq_pkg::PRI_W-1:0];
        new_job.waited = '0;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        n_next         = n_reg;
        ptr_next       = ptr_reg;
        aged_next      = aged_reg;
        next_code_next = next_code_reg;
        job_next       = job_reg;
        raise_next     = raise_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        out_next       = out_reg;
        div_start      = 1'b0;
        cell_cmd.op    = apq_pkg::OP_NOP;
        cell_cmd.tgt   = ptr_reg;
        cell_cmd.x     = aged_job;
        cell_cmd.xmark = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    // Clear the aged marks and start a pass over the n jobs.
                    cell_cmd.op = apq_pkg::OP_CLR;
                    n_next      = count_reg;
                    ptr_next    = '0;
                    aged_next   = '0;
                    state_next  = S_SEL;
                end
            end
            S_SEL:
            begin
                if (aged_reg == n_reg)
                begin
                    state_next = S_CMD;
                end
                else if (sel_slot.mark)
                begin
                    // A job moved earlier in this pass; step over it.
                    ptr_next = ptr_reg + 1'b1;
                end
                else
                begin
                    job_next   = sel_slot.job;
                    raise_next = 1'b0;
                    if (sel_slot.job.waited == apq_pkg::WAIT_MAX)
                    begin
                        state_next = S_APPLY;
                    end
                    else
                    begin
                        job_next.waited = sel_slot.job.waited + 1'b1;
                        if (aging_period_reg == '0)
                        begin
                            state_next = S_APPLY;
                        end
                        else
                        begin
                            state_next = S_DIV;
                        end
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    raise_next = (div_rem == '0);
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                aged_next  = aged_reg + 1'b1;
                state_next = S_SEL;
                if (raise_reg && (aged_reg != '0))
                begin
                    cell_cmd.op = apq_pkg::OP_MOVE;
                    if (back_flag)
                    begin
                        ptr_next = ptr_reg;
                    end
                    else
                    begin
                        ptr_next = ptr_reg + 1'b1;
                    end
                end
                else
                begin
                    cell_cmd.op = apq_pkg::OP_WRITE;
                    ptr_next    = ptr_reg + 1'b1;
                end
            end
            S_CMD:
            begin
                out_next   = '0;
                state_next = S_IDLE;
                done_next  = 1'b1;
                case (cmd_reg)
                    apq_pkg::CMD_INSERT:
                    begin
                        if (count_reg == CW'(N))
                        begin
                            status_next = apq_pkg::ST_FULL;
                        end
                        else
                        begin
                            cell_cmd.op    = apq_pkg::OP_MOVE;
                            cell_cmd.tgt   = count_reg;
                            cell_cmd.x     = new_job;
                            cell_cmd.xmark = 1'b0;
                            count_next     = count_reg + 1'b1;
                            next_code_next = next_code_reg + 1'b1;
                            status_next    = apq_pkg::ST_INSERTED;
                            out_next.code  = next_code_reg;
                        end
                    end
                    apq_pkg::CMD_PRINT:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = apq_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            cell_cmd.op = apq_pkg::OP_POP;
                            count_next  = count_reg - 1'b1;
                            status_next = apq_pkg::ST_PRINTED;
                            out_next    = slots[0].job;
                        end
                    end
                    apq_pkg::CMD_QUERY:
                    begin
                        done_next  = 1'b0;
                        ptr_next   = '0;
                        state_next = S_SCAN;
                    end
                    default:
                    begin
                        status_next = apq_pkg::ST_AGED;
                    end
                endcase
            end
            S_SCAN:
            begin
                if (ptr_reg == count_reg)
                begin
                    status_next = apq_pkg::ST_NOT_FOUND;
                    out_next    = '0;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (sel_slot.job.code == qcode_reg)
                begin
                    status_next = apq_pkg::ST_FOUND;
                    out_next    = sel_slot.job;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if ((state_reg == S_SEL) && (state_next == S_DIV))
        begin
            div_start = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            n_reg            <= '0;
            ptr_reg          <= '0;
            aged_reg         <= '0;
            next_code_reg    <= '0;
            done_reg         <= 1'b0;
            raise_reg        <= 1'b0;
            role_weight_reg  <= 4'd3;
            dept_weight_reg  <= 4'd2;
            aging_period_reg <= 8'd5;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            n_reg         <= n_next;
            ptr_reg       <= ptr_next;
            aged_reg      <= aged_next;
            next_code_reg <= next_code_next;
            done_reg      <= done_next;
            raise_reg     <= raise_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    apq_pkg::REG_ROLE_WEIGHT:
                    begin
                        role_weight_reg <= cfg_data[apq_pkg::WEIGHT_W-1:0];
                    end
                    apq_pkg::REG_DEPT_WEIGHT:
                    begin
                        dept_weight_reg <= cfg_data[apq_pkg::WEIGHT_W-1:0];
                    end
                    apq_pkg::REG_AGING_PERIOD:
                    begin
                        aging_period_reg <= cfg_data[apq_pkg::PERIOD_W-1:0];
                    end
                    default:
                    begin
                        role_weight_reg <= role_weight_reg;
                    end
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= command;
            dept_reg  <= department;
            role_reg  <= role;
            urg_reg   <= urgency;
            qcode_reg <= query_code;
        end
        job_reg    <= job_next;
        status_reg <= status_next;
        out_reg    <= out_next;
    end

    assign done           = done_reg;
    assign status         = status_reg;
    assign job_code       = out_reg.code;
    assign job_department = out_reg.dept;
    assign job_role       = out_reg.role;
    assign job_urgency    = out_reg.urg;
    assign job_priority   = out_reg.pri;
    assign job_wait       = out_reg.waited;

    // The queue never holds more jobs than it has cells.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(N))
    else $error("job count beyond queue depth");

    // A result is shown only right after a command or search step.
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) == S_CMD || $past(state_reg) == S_SCAN))
    else $error("result strobe without a finished command");

    // The aging pointer stays on a queued job while a job is applied.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_APPLY) |-> (ptr_reg < count_reg))
    else $error("aging pointer outside the queue");

    // An accepted item always starts with an aging pass.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_SEL))
    else $error("item did not enter the aging pass");

    // The aging pass never counts more jobs than it started with.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEL) |-> (aged_reg <= n_reg))
    else $error("aging pass overran");

endmodule
